// ===== rtl/usage_latency_stats_tracker_unit_macros.svh =====
// ----------------------------------------------------------------------------
// usage latency stats tracker assertion macros
// concurrent assertion shorthands, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef USAGE_LATENCY_STATS_TRACKER_UNIT_MACROS_SVH
`define USAGE_LATENCY_STATS_TRACKER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off during reset
`define ULST_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("ulst assertion failed");
// next-cycle implication
`define ULST_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("ulst assertion failed");
`else
`define ULST_ASSERT_IMP(lbl, a, c)
`define ULST_ASSERT_NXT(lbl, a, c)
`endif

`endif

// ===== rtl/ulst_pkg.sv =====
// ----------------------------------------------------------------------------
// ulst_pkg
// types, codes and helpers of the usage latency stats tracker
// ----------------------------------------------------------------------------
package ulst_pkg;

  localparam int CNT_W            = 48;
  localparam int LAT_W            = 31;
  localparam int LAT_BIT_W        = 5;
  localparam int CNT_PER_SLOT     = 16;
  localparam int WINDOW_DEPTH_DEF = 256;
  localparam int SOURCE_SLOTS_DEF = 8;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // opcodes
  localparam logic [3:0] OP_REQUEST  = 4'd0;
  localparam logic [3:0] OP_DECLINE  = 4'd1;
  localparam logic [3:0] OP_CANCEL   = 4'd2;
  localparam logic [3:0] OP_ERROR    = 4'd3;
  localparam logic [3:0] OP_DISMISS  = 4'd4;
  localparam logic [3:0] OP_DELIVERY = 4'd5;
  localparam logic [3:0] OP_ACCEPT   = 4'd6;
  localparam logic [3:0] OP_FINISH   = 4'd7;
  localparam logic [3:0] OP_QUERY    = 4'd8;

  // accept kinds
  localparam logic [1:0] KIND_WORD = 2'd0;
  localparam logic [1:0] KIND_LINE = 2'd1;

  // counter words inside one slot
  localparam logic [3:0] C_REQ     = 4'd0;
  localparam logic [3:0] C_DECL    = 4'd1;
  localparam logic [3:0] C_DELIV   = 4'd2;
  localparam logic [3:0] C_CANC    = 4'd3;
  localparam logic [3:0] C_ERR     = 4'd4;
  localparam logic [3:0] C_ACC_W   = 4'd5;
  localparam logic [3:0] C_ACC_L   = 4'd6;
  localparam logic [3:0] C_ACC_A   = 4'd7;
  localparam logic [3:0] C_DISM    = 4'd8;
  localparam logic [3:0] C_B_SUG   = 4'd9;
  localparam logic [3:0] C_B_ACC   = 4'd10;
  localparam logic [3:0] C_LAT_SUM = 4'd11;
  localparam logic [3:0] C_LAT_N   = 4'd12;
  localparam logic [3:0] C_TOK_IN  = 4'd13;
  localparam logic [3:0] C_TOK_OUT = 4'd14;

  typedef enum logic [3:0] {
    SEL_ONE,
    SEL_BYTES,
    SEL_LAT,
    SEL_LATN,
    SEL_TIN,
    SEL_TOUT,
    SEL_RD_REQ,
    SEL_RD_DELIV,
    SEL_RD_ACC0,
    SEL_RD_ACCN,
    SEL_RD_TOK
  } sel_t;

  typedef struct packed {
    logic [3:0] idx;
    sel_t       sel;
    logic       last;
  } step_t;

  typedef struct packed {
    logic        [3:0]  opcode;
    logic        [2:0]  source_slot;
    logic        [1:0]  accept_kind;
    logic        [31:0] byte_count;
    logic signed [31:0] latency_ms;
    logic signed [31:0] tokens_in_count;
    logic signed [31:0] tokens_out_count;
  } in_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] requests_total;
    logic [CNT_W-1:0] delivered_total;
    logic [CNT_W-1:0] accepted_total;
    logic [LAT_W-1:0] median_latency_ms;
    logic [LAT_W-1:0] max_latency_ms;
    logic [CNT_W-1:0] tokens_out_total;
  } out_item_t;

  function automatic logic [CNT_W-1:0] add_sat48(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= {1'b0, CNT_MAX}) ? CNT_MAX : s[CNT_W-1:0];
  endfunction

  // counter word and operand of each read-modify-write or read-only step of an opcode
  function automatic step_t step_desc(input logic [3:0] op, input logic [1:0] kind,
                                      input logic [2:0] step);
    step_t d;
    d = '{idx: C_REQ, sel: SEL_ONE, last: 1'b1};
    case (op)
      OP_REQUEST: d.idx = C_REQ;
      OP_DECLINE: d.idx = C_DECL;
      OP_CANCEL:  d.idx = C_CANC;
      OP_ERROR:   d.idx = C_ERR;
      OP_DISMISS: d.idx = C_DISM;
      OP_DELIVERY: begin
        if (step == 3'd0) d = '{idx: C_DELIV, sel: SEL_ONE, last: 1'b0};
        else              d = '{idx: C_B_SUG, sel: SEL_BYTES, last: 1'b1};
      end
      OP_ACCEPT: begin
        if (step == 3'd0) begin
          if (kind == KIND_WORD)      d = '{idx: C_ACC_W, sel: SEL_ONE, last: 1'b0};
          else if (kind == KIND_LINE) d = '{idx: C_ACC_L, sel: SEL_ONE, last: 1'b0};
          else                        d = '{idx: C_ACC_A, sel: SEL_ONE, last: 1'b0};
        end else begin
          d = '{idx: C_B_ACC, sel: SEL_BYTES, last: 1'b1};
        end
      end
      OP_FINISH: begin
        case (step)
          3'd0:    d = '{idx: C_LAT_SUM, sel: SEL_LAT, last: 1'b0};
          3'd1:    d = '{idx: C_LAT_N, sel: SEL_LATN, last: 1'b0};
          3'd2:    d = '{idx: C_TOK_IN, sel: SEL_TIN, last: 1'b0};
          default: d = '{idx: C_TOK_OUT, sel: SEL_TOUT, last: 1'b1};
        endcase
      end
      OP_QUERY: begin
        case (step)
          3'd0:    d = '{idx: C_REQ, sel: SEL_RD_REQ, last: 1'b0};
          3'd1:    d = '{idx: C_DELIV, sel: SEL_RD_DELIV, last: 1'b0};
          3'd2:    d = '{idx: C_ACC_W, sel: SEL_RD_ACC0, last: 1'b0};
          3'd3:    d = '{idx: C_ACC_L, sel: SEL_RD_ACCN, last: 1'b0};
          3'd4:    d = '{idx: C_ACC_A, sel: SEL_RD_ACCN, last: 1'b0};
          default: d = '{idx: C_TOK_OUT, sel: SEL_RD_TOK, last: 1'b1};
        endcase
      end
      default: d = '{idx: C_REQ, sel: SEL_ONE, last: 1'b1};
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/ulst_ram.sv =====
// ----------------------------------------------------------------------------
// ulst_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module ulst_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/usage_latency_stats_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// usage_latency_stats_tracker_unit
// per-slot event counters, latency ring and lower-median query engine
// ----------------------------------------------------------------------------
// usage:
//   drive in_data and raise start; the beat is taken on a rising edge with
//   start high and busy low. every beat yields exactly one result beat on
//   out_data, marked by out_valid for one cycle; the receiver cannot stall
//   it, and only a query beat carries nonzero fields.
// sequence, from the accepting edge to the strobe:
//   bad opcode or slot: the strobe is registered at the accepting edge itself, the block stays free
//   event ops: each counter touched (one, two or four) is read in ST_CRD and
//   written back in ST_CWR, one counter at a time through the counter memory
//   query: six counter words are read the same way, then when the ring holds
//   n > 0 values a bit-by-bit radix select makes 31 passes over the ring
//   memory, each pass reading all n stored values of the slot
//   one item is in work at a time; busy stays high until the strobe
// reset:
//   rst_n low clears the slot registers; after it a clearing pass writes
//   zero through every counter memory word, with busy high
// ----------------------------------------------------------------------------
`include "usage_latency_stats_tracker_unit_macros.svh"

module usage_latency_stats_tracker_unit #(
  parameter int WINDOW_DEPTH = ulst_pkg::WINDOW_DEPTH_DEF,
  parameter int SOURCE_SLOTS = ulst_pkg::SOURCE_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ulst_pkg::in_item_t  in_data,
  output logic                out_valid,
  output ulst_pkg::out_item_t out_data
);

  localparam int PW     = $clog2(WINDOW_DEPTH);
  localparam int FW     = $clog2(WINDOW_DEPTH + 1);
  localparam int SW     = (SOURCE_SLOTS > 1) ? $clog2(SOURCE_SLOTS) : 1;
  localparam int CDEPTH = SOURCE_SLOTS * ulst_pkg::CNT_PER_SLOT;
  localparam int CAW    = $clog2(CDEPTH);
  localparam int RDEPTH = SOURCE_SLOTS * WINDOW_DEPTH;
  localparam int RAW    = $clog2(RDEPTH);
  localparam int CW     = ulst_pkg::CNT_W;
  localparam int LW     = ulst_pkg::LAT_W;
  localparam int BW     = ulst_pkg::LAT_BIT_W;

  typedef enum logic [4:0] {
    ST_CLR  = 5'b00001,
    ST_IDLE = 5'b00010,
    ST_CRD  = 5'b00100,
    ST_CWR  = 5'b01000,
    ST_MED  = 5'b10000
  } state_t;

  // control state
  state_t              state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [CAW-1:0]      clr_r, clr_nxt;
  logic [PW-1:0]       pos_r  [SOURCE_SLOTS];
  logic [PW-1:0]       pos_nxt[SOURCE_SLOTS];
  logic [FW-1:0]       fill_r  [SOURCE_SLOTS];
  logic [FW-1:0]       fill_nxt[SOURCE_SLOTS];
  logic [LW-1:0]       peak_r  [SOURCE_SLOTS];
  logic [LW-1:0]       peak_nxt[SOURCE_SLOTS];

  // working registers of the current beat
  ulst_pkg::in_item_t  item_r, item_nxt;
  ulst_pkg::out_item_t out_r, out_nxt;
  logic [2:0]          step_r, step_nxt;
  logic [FW-1:0]       n_r, n_nxt;
  logic [FW-1:0]       iss_r, iss_nxt;
  logic                rvld_r, rvld_nxt;
  logic [FW-1:0]       cnt0_r, cnt0_nxt;
  logic [FW-1:0]       rank_r, rank_nxt;
  logic [LW-1:0]       med_r, med_nxt;
  logic [LW-1:0]       mask_r, mask_nxt;
  logic [BW-1:0]       bit_r, bit_nxt;
  logic [RAW-1:0]      ring_base_r, ring_base_nxt;

  // decode
  logic                accept;
  logic                in_ok;
  logic [SW-1:0]       in_ix, item_ix;
  logic                in_lat_ok;
  logic [LW-1:0]       in_lat;
  ulst_pkg::step_t     desc;

  // counter memory
  logic                cnt_we;
  logic [CAW-1:0]      cnt_waddr, cnt_raddr;
  logic [CW-1:0]       cnt_wdata, cnt_rdata;
  logic [CW-1:0]       amount;
  logic                wr_sel;

  // ring memory
  logic                ring_we;
  logic [RAW-1:0]      ring_waddr, ring_raddr;
  logic [LW-1:0]       ring_rdata;

  // median search
  logic                issuing;
  logic                med_match;
  logic [LW-1:0]       bit_oh;
  logic [LW-1:0]       med_dec;

  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign in_ok     = (32'(in_data.source_slot) < SOURCE_SLOTS) &&
                     (in_data.opcode <= ulst_pkg::OP_QUERY);
  assign in_ix     = SW'(in_data.source_slot);
  assign item_ix   = SW'(item_r.source_slot);
  assign in_lat_ok = !in_data.latency_ms[31];
  assign in_lat    = in_data.latency_ms[LW-1:0];

  assign desc = ulst_pkg::step_desc(item_r.opcode, item_r.accept_kind, step_r);

  // operand of the counter update, negative values add nothing
  always_comb begin
    amount = '0;
    wr_sel = 1'b1;
    case (desc.sel)
      ulst_pkg::SEL_ONE:   amount = CW'(1);
      ulst_pkg::SEL_BYTES: amount = CW'(item_r.byte_count);
      ulst_pkg::SEL_LAT: begin
        if (!item_r.latency_ms[31]) amount = CW'(item_r.latency_ms[LW-1:0]);
      end
      ulst_pkg::SEL_LATN: begin
        if (!item_r.latency_ms[31]) amount = CW'(1);
      end
      ulst_pkg::SEL_TIN: begin
        if (!item_r.tokens_in_count[31]) amount = CW'(item_r.tokens_in_count[30:0]);
      end
      ulst_pkg::SEL_TOUT: begin
        if (!item_r.tokens_out_count[31]) amount = CW'(item_r.tokens_out_count[30:0]);
      end
      default: wr_sel = 1'b0;
    endcase
  end

  // slot words sit at slot * 16 + word
  assign cnt_raddr = CAW'({item_r.source_slot, desc.idx});
  assign cnt_we    = (state_r == ST_CLR) || ((state_r == ST_CWR) && wr_sel);
  assign cnt_waddr = (state_r == ST_CLR) ? clr_r : cnt_raddr;
  assign cnt_wdata = (state_r == ST_CLR) ? '0 : ulst_pkg::add_sat48(cnt_rdata, amount);

  ulst_ram #(
    .WIDTH (CW),
    .DEPTH (CDEPTH)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  // finish with a valid latency drops it into the slot's ring
  assign ring_we    = accept && in_ok && (in_data.opcode == ulst_pkg::OP_FINISH) &&
                      in_lat_ok;
  assign ring_waddr = RAW'(32'(in_data.source_slot) * WINDOW_DEPTH) + RAW'(pos_r[in_ix]);
  assign ring_raddr = ring_base_r + RAW'(iss_r[PW-1:0]);

  ulst_ram #(
    .WIDTH (LW),
    .DEPTH (RDEPTH)
  ) u_ring_ram (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wdata (in_lat),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  // radix select: count entries that share the decided high bits and
  // have a zero in the current bit
  assign issuing   = (iss_r != n_r);
  assign med_match = (((ring_rdata ^ med_r) & mask_r) == '0) && !ring_rdata[bit_r];
  assign bit_oh    = LW'(1) << bit_r;
  assign med_dec   = (cnt0_r > rank_r) ? med_r : (med_r | bit_oh);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    clr_nxt       = clr_r;
    pos_nxt       = pos_r;
    fill_nxt      = fill_r;
    peak_nxt      = peak_r;
    item_nxt      = item_r;
    out_nxt       = out_r;
    step_nxt      = step_r;
    n_nxt         = n_r;
    iss_nxt       = iss_r;
    rvld_nxt      = rvld_r;
    cnt0_nxt      = cnt0_r;
    rank_nxt      = rank_r;
    med_nxt       = med_r;
    mask_nxt      = mask_r;
    bit_nxt       = bit_r;
    ring_base_nxt = ring_base_r;

    case (state_r)
      ST_CLR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == CAW'(CDEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          item_nxt = in_data;
          out_nxt  = '0;
          step_nxt = '0;
          if (!in_ok) begin
            // bad slot or opcode: zero result at once
            out_valid_nxt = 1'b1;
          end else begin
            state_nxt = ST_CRD;
            if ((in_data.opcode == ulst_pkg::OP_FINISH) && in_lat_ok) begin
              pos_nxt[in_ix] = (pos_r[in_ix] == PW'(WINDOW_DEPTH - 1)) ? '0 :
                               pos_r[in_ix] + 1'b1;
              if (fill_r[in_ix] != FW'(WINDOW_DEPTH)) begin
                fill_nxt[in_ix] = fill_r[in_ix] + 1'b1;
              end
              if (in_lat > peak_r[in_ix]) peak_nxt[in_ix] = in_lat;
            end
            n_nxt         = fill_r[in_ix];
            ring_base_nxt = RAW'(32'(in_data.source_slot) * WINDOW_DEPTH);
          end
        end
      end
      ST_CRD: begin
        state_nxt = ST_CWR;
      end
      ST_CWR: begin
        case (desc.sel)
          ulst_pkg::SEL_RD_REQ:   out_nxt.requests_total  = cnt_rdata;
          ulst_pkg::SEL_RD_DELIV: out_nxt.delivered_total = cnt_rdata;
          ulst_pkg::SEL_RD_ACC0:  out_nxt.accepted_total  = cnt_rdata;
          ulst_pkg::SEL_RD_ACCN:  out_nxt.accepted_total  =
                                    ulst_pkg::add_sat48(out_r.accepted_total, cnt_rdata);
          ulst_pkg::SEL_RD_TOK:   out_nxt.tokens_out_total = cnt_rdata;
          default: ;
        endcase
        if (desc.last) begin
          if (item_r.opcode == ulst_pkg::OP_QUERY) begin
            out_nxt.max_latency_ms = peak_r[item_ix];
          end
          if ((item_r.opcode == ulst_pkg::OP_QUERY) && (n_r != '0)) begin
            state_nxt = ST_MED;
            iss_nxt   = '0;
            rvld_nxt  = 1'b0;
            cnt0_nxt  = '0;
            rank_nxt  = (n_r - 1'b1) >> 1;
            med_nxt   = '0;
            mask_nxt  = '0;
            bit_nxt   = BW'(LW - 1);
          end else begin
            state_nxt     = ST_IDLE;
            out_valid_nxt = 1'b1;
          end
        end else begin
          step_nxt  = step_r + 1'b1;
          state_nxt = ST_CRD;
        end
      end
      ST_MED: begin
        if (issuing) iss_nxt = iss_r + 1'b1;
        rvld_nxt = issuing;
        if (rvld_r && med_match) cnt0_nxt = cnt0_r + 1'b1;
        if (!issuing && !rvld_r) begin
          // end of one bit pass
          if (cnt0_r <= rank_r) rank_nxt = rank_r - cnt0_r;
          med_nxt  = med_dec;
          mask_nxt = mask_r | bit_oh;
          cnt0_nxt = '0;
          iss_nxt  = '0;
          if (bit_r == '0) begin
            out_nxt.median_latency_ms = med_dec;
            out_valid_nxt             = 1'b1;
            state_nxt                 = ST_IDLE;
          end else begin
            bit_nxt = bit_r - 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      out_valid_r <= 1'b0;
      clr_r       <= '0;
      for (int i = 0; i < SOURCE_SLOTS; i++) begin
        pos_r[i]  <= '0;
        fill_r[i] <= '0;
        peak_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      clr_r       <= clr_nxt;
      pos_r       <= pos_nxt;
      fill_r      <= fill_nxt;
      peak_r      <= peak_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    out_r       <= out_nxt;
    step_r      <= step_nxt;
    n_r         <= n_nxt;
    iss_r       <= iss_nxt;
    rvld_r      <= rvld_nxt;
    cnt0_r      <= cnt0_nxt;
    rank_r      <= rank_nxt;
    med_r       <= med_nxt;
    mask_r      <= mask_nxt;
    bit_r       <= bit_nxt;
    ring_base_r <= ring_base_nxt;
  end

  // only a query beat carries data
  `ULST_ASSERT_IMP(a_nonquery_zero, out_valid_r && (item_r.opcode != ulst_pkg::OP_QUERY), out_r == '0)
  // the select counters stay inside the ring fill
  `ULST_ASSERT_IMP(a_med_bounds, state_r == ST_MED, (cnt0_r <= n_r) && (rank_r < n_r))
  // a good beat always starts a counter walk
  `ULST_ASSERT_NXT(a_accept_busy, accept && in_ok, busy && !out_valid_r)

endmodule

// ===== bench/usage_latency_stats_tracker_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usage_latency_stats_tracker_unit_tb
// self-checking bench: directed table, a ring wrap run, then about 400 random beats, every
// result compared field by field with a typed zero or an in-bench copy of the slot statistics
// ----------------------------------------------------------------------------
module usage_latency_stats_tracker_unit_tb;

  localparam int SLOTS = ulst_pkg::SOURCE_SLOTS_DEF;
  localparam int DEPTH = ulst_pkg::WINDOW_DEPTH_DEF;
  localparam int CW = ulst_pkg::CNT_W;
  localparam int LW = ulst_pkg::LAT_W;
  localparam int NCNT = ulst_pkg::CNT_PER_SLOT;
  localparam logic [3:0] OP_UNUSED = 4'd15;
  localparam logic [1:0] KIND_ALL = 2'd2;
  localparam logic [1:0] KIND_ALL_ALT = 2'd3;
  localparam int RANDOM_BEATS = 416;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic out_valid;
  ulst_pkg::in_item_t in_data = '0;
  ulst_pkg::out_item_t out_data;

  // typed expectation riding along with the beat on the input
  logic typed_on = 1'b0;
  ulst_pkg::out_item_t typed_result = '0;

  int unsigned mismatches = 0;

  always #5 clk = ~clk;

  usage_latency_stats_tracker_unit uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  // shadow of the per-slot statistics
  logic [CW-1:0] stat_cnt [SLOTS][NCNT];
  logic [LW-1:0] lat_window [SLOTS][DEPTH];
  int unsigned win_pos [SLOTS];
  int unsigned win_fill [SLOTS];
  logic [LW-1:0] lat_peak [SLOTS];

  ulst_pkg::out_item_t pending_results[$];

  function automatic logic [CW-1:0] sat_sum(logic [CW-1:0] a, logic [CW-1:0] b);
    logic [CW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= {1'b0, ulst_pkg::CNT_MAX}) ? ulst_pkg::CNT_MAX : s[CW-1:0];
  endfunction

  function automatic void bump_stat(int slot, logic [3:0] k, logic [CW-1:0] amt);
    stat_cnt[slot][k] = sat_sum(stat_cnt[slot][k], amt);
  endfunction

  // lower median over the stored part of the window
  function automatic logic [LW-1:0] window_median(int slot);
    int unsigned vals[$];
    if (win_fill[slot] == 0) return '0;
    for (int i = 0; i < win_fill[slot]; i++) vals.push_back(lat_window[slot][i]);
    vals.sort();
    return LW'(vals[(win_fill[slot] - 1) / 2]);
  endfunction

  // applies one beat to the shadow state and returns its result
  function automatic ulst_pkg::out_item_t apply_event(ulst_pkg::in_item_t it);
    ulst_pkg::out_item_t r;
    int s;
    logic [CW-1:0] acc;
    r = '0;
    s = it.source_slot;
    case (it.opcode)
      ulst_pkg::OP_REQUEST: bump_stat(s, ulst_pkg::C_REQ, 1);
      ulst_pkg::OP_DECLINE: bump_stat(s, ulst_pkg::C_DECL, 1);
      ulst_pkg::OP_CANCEL:  bump_stat(s, ulst_pkg::C_CANC, 1);
      ulst_pkg::OP_ERROR:   bump_stat(s, ulst_pkg::C_ERR, 1);
      ulst_pkg::OP_DISMISS: bump_stat(s, ulst_pkg::C_DISM, 1);
      ulst_pkg::OP_DELIVERY: begin
        bump_stat(s, ulst_pkg::C_DELIV, 1);
        bump_stat(s, ulst_pkg::C_B_SUG, CW'(it.byte_count));
      end
      ulst_pkg::OP_ACCEPT: begin
        if (it.accept_kind == ulst_pkg::KIND_WORD) bump_stat(s, ulst_pkg::C_ACC_W, 1);
        else if (it.accept_kind == ulst_pkg::KIND_LINE) bump_stat(s, ulst_pkg::C_ACC_L, 1);
        else bump_stat(s, ulst_pkg::C_ACC_A, 1);
        bump_stat(s, ulst_pkg::C_B_ACC, CW'(it.byte_count));
      end
      ulst_pkg::OP_FINISH: begin
        // negative latency means no latency; tokens still count
        if (!it.latency_ms[31]) begin
          bump_stat(s, ulst_pkg::C_LAT_SUM, CW'(it.latency_ms[30:0]));
          if (it.latency_ms[30:0] > lat_peak[s]) lat_peak[s] = it.latency_ms[30:0];
          bump_stat(s, ulst_pkg::C_LAT_N, 1);
          lat_window[s][win_pos[s]] = it.latency_ms[30:0];
          win_pos[s] = (win_pos[s] + 1) % DEPTH;
          if (win_fill[s] < DEPTH) win_fill[s]++;
        end
        if (it.tokens_in_count > 0)
          bump_stat(s, ulst_pkg::C_TOK_IN, CW'(it.tokens_in_count[30:0]));
        if (it.tokens_out_count > 0)
          bump_stat(s, ulst_pkg::C_TOK_OUT, CW'(it.tokens_out_count[30:0]));
      end
      ulst_pkg::OP_QUERY: begin
        acc = sat_sum(stat_cnt[s][ulst_pkg::C_ACC_W], stat_cnt[s][ulst_pkg::C_ACC_L]);
        r.requests_total = stat_cnt[s][ulst_pkg::C_REQ];
        r.delivered_total = stat_cnt[s][ulst_pkg::C_DELIV];
        r.accepted_total = sat_sum(acc, stat_cnt[s][ulst_pkg::C_ACC_A]);
        r.median_latency_ms = window_median(s);
        r.max_latency_ms = lat_peak[s];
        r.tokens_out_total = stat_cnt[s][ulst_pkg::C_TOK_OUT];
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %0h actual %0h", name, exp_v, act_v);
    end
  endfunction

  // accept and result beats, sampled on the rising edge
  always @(posedge clk) begin
    ulst_pkg::out_item_t e;
    ulst_pkg::out_item_t p;
    if (rst_n) begin
      if (out_valid) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: result beat with nothing expected");
        end else begin
          e = pending_results.pop_front();
          check_field("requests_total", 64'(e.requests_total),
                      64'(out_data.requests_total));
          check_field("delivered_total", 64'(e.delivered_total),
                      64'(out_data.delivered_total));
          check_field("accepted_total", 64'(e.accepted_total),
                      64'(out_data.accepted_total));
          check_field("median_latency_ms", 64'(e.median_latency_ms),
                      64'(out_data.median_latency_ms));
          check_field("max_latency_ms", 64'(e.max_latency_ms),
                      64'(out_data.max_latency_ms));
          check_field("tokens_out_total", 64'(e.tokens_out_total),
                      64'(out_data.tokens_out_total));
        end
      end
      if (start && !busy) begin
        p = apply_event(in_data);
        pending_results.push_back(typed_on ? typed_result : p);
      end
    end
  end

  // present one beat and hold it until the block takes it
  task automatic send_beat(ulst_pkg::in_item_t it, bit use_typed, ulst_pkg::out_item_t typed);
    in_data <= it;
    typed_on <= use_typed;
    typed_result <= typed;
    start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_gap(int pct);
    if (pct > 0 && $urandom_range(99) < pct) begin
      start <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic ulst_pkg::in_item_t make_beat(logic [3:0] op, logic [2:0] slot,
                                                   logic [1:0] kind, logic [31:0] bytes,
                                                   logic [31:0] lat, logic [31:0] tin,
                                                   logic [31:0] tout);
    ulst_pkg::in_item_t it;
    it.opcode = op;
    it.source_slot = slot;
    it.accept_kind = kind;
    it.byte_count = bytes;
    it.latency_ms = lat;
    it.tokens_in_count = tin;
    it.tokens_out_count = tout;
    return it;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(3))
      0: return $urandom_range(50);
      1: return -$urandom_range(50);
      default: return $urandom;
    endcase
  endfunction

  // mostly valid events with random content, some queries, a few unused codes
  function automatic ulst_pkg::in_item_t random_beat();
    logic [3:0] op;
    int pick;
    pick = $urandom_range(99);
    if (pick < 5) op = OP_UNUSED - 4'($urandom_range(6));
    else if (pick < 20) op = ulst_pkg::OP_QUERY;
    else if (pick < 40) op = ulst_pkg::OP_FINISH;
    else op = 4'($urandom_range(ulst_pkg::OP_ACCEPT));
    return make_beat(op, 3'($urandom_range(SLOTS - 1)), 2'($urandom), $urandom,
                     rand_word(), rand_word(), rand_word());
  endfunction

  typedef struct {
    ulst_pkg::in_item_t beat;
    bit typed;
  } stim_row_t;

  stim_row_t stim_table[] = '{
    // fresh block reads all zero; events and unused codes return zero fields
    '{make_beat(ulst_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0), 1},
    '{make_beat(ulst_pkg::OP_REQUEST, 0, 0, 0, 0, 0, 0), 1},
    '{make_beat(OP_UNUSED, 7, 3, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF), 1},
    '{make_beat(ulst_pkg::OP_DECLINE, 0, 0, 0, 0, 0, 0), 1},
    '{make_beat(ulst_pkg::OP_CANCEL, 0, 0, 0, 0, 0, 0), 1},
    '{make_beat(ulst_pkg::OP_ERROR, 0, 0, 0, 0, 0, 0), 1},
    '{make_beat(ulst_pkg::OP_DISMISS, 0, 0, 0, 0, 0, 0), 1},
    '{make_beat(ulst_pkg::OP_DELIVERY, 0, 0, 32'hFFFFFFFF, 0, 0, 0), 1},
    '{make_beat(ulst_pkg::OP_ACCEPT, 0, ulst_pkg::KIND_WORD, 32'hFFFFFFFF, 0, 0, 0), 1},
    '{make_beat(ulst_pkg::OP_ACCEPT, 0, ulst_pkg::KIND_LINE, 0, 0, 0, 0), 0},
    '{make_beat(ulst_pkg::OP_ACCEPT, 0, KIND_ALL, 5, 0, 0, 0), 0},
    '{make_beat(ulst_pkg::OP_ACCEPT, 0, KIND_ALL_ALT, 7, 0, 0, 0), 0},
    '{make_beat(ulst_pkg::OP_FINISH, 0, 0, 0, 0, 0, 0), 1},
    '{make_beat(ulst_pkg::OP_FINISH, 0, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF), 0},
    // negative latency and negative tokens are dropped
    '{make_beat(ulst_pkg::OP_FINISH, 0, 0, 0, 32'h80000000, 32'h80000000, 32'h80000000), 0},
    '{make_beat(ulst_pkg::OP_FINISH, 0, 0, 0, 32'hFFFFFFFF, 32'hFFFFFFFF, 1), 0},
    '{make_beat(ulst_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0), 0},
    '{make_beat(ulst_pkg::OP_QUERY, 3, 0, 0, 0, 0, 0), 1},
    '{make_beat(ulst_pkg::OP_FINISH, 7, 0, 0, 9, 0, 3), 0},
    '{make_beat(ulst_pkg::OP_FINISH, 7, 0, 0, 2, 0, 0), 0},
    '{make_beat(ulst_pkg::OP_QUERY, 7, 0, 0, 0, 0, 0), 0}
  };

  // stimulus
  initial begin
    int idle_pct [4] = '{0, 88, 0, 13};
    for (int s = 0; s < SLOTS; s++) begin
      for (int k = 0; k < NCNT; k++) stat_cnt[s][k] = '0;
      for (int d = 0; d < DEPTH; d++) lat_window[s][d] = '0;
      win_pos[s] = 0;
      win_fill[s] = 0;
      lat_peak[s] = '0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_table[i]) send_beat(stim_table[i].beat, stim_table[i].typed, '0);
    drain_results();

    // window wrap: more finishes than the ring holds, then a full-ring median
    for (int i = 0; i < DEPTH + 5; i++)
      send_beat(make_beat(ulst_pkg::OP_FINISH, 5, 0, 0, $urandom_range(100000), 1, 1),
                0, '0);
    send_beat(make_beat(ulst_pkg::OP_QUERY, 5, 0, 0, 0, 0, 0), 0, '0);
    drain_results();

    for (int ph = 0; ph < 4; ph++) begin
      for (int i = 0; i < RANDOM_BEATS / 4; i++) begin
        // keep the wrapped slot out of random queries, its median is slow
        ulst_pkg::in_item_t b;
        b = random_beat();
        if (b.opcode == ulst_pkg::OP_QUERY && b.source_slot == 5) b.source_slot = 4;
        send_beat(b, 0, '0);
        idle_gap(idle_pct[ph]);
      end
      drain_results();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #50_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
